/* hw/rtl/nlp_pkg.sv */
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared types and constants for the next lexicographic permutation block.
// ----------------------------------------------------------------------------
`default_nettype none

package nlp_pkg;

    // Sequence geometry, fixed by the word layout below.
    localparam int MAX_ELEMS = 8;
    localparam int ELEM_BITS = 8;
    localparam int LEN_BITS  = 4;
    localparam int IDX_BITS  = $clog2(MAX_ELEMS);

    typedef logic [ELEM_BITS-1:0] elem_t;
    typedef logic [LEN_BITS-1:0]  len_t;
    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef elem_t [MAX_ELEMS-1:0] seq_t;
    typedef logic [MAX_ELEMS-2:0] asc_t;

    // Input word.
    typedef struct packed {
        elem_t elem_0;
        elem_t elem_1;
        elem_t elem_2;
        elem_t elem_3;
        elem_t elem_4;
        elem_t elem_5;
        elem_t elem_6;
        elem_t elem_7;
        len_t  length;
    } in_word_t;

    // Result word.
    typedef struct packed {
        elem_t out_0;
        elem_t out_1;
        elem_t out_2;
        elem_t out_3;
        elem_t out_4;
        elem_t out_5;
        elem_t out_6;
        elem_t out_7;
        logic  has_next;
    } out_word_t;

    // Word handed from the scan stages to the swap stages.
    typedef struct packed {
        logic valid;
        seq_t seq;
        len_t n;
        idx_t pivot;
        logic found;
    } scan_t;

    // Gathers the elements of an input word into an indexed sequence.
    function automatic seq_t to_seq(input in_word_t w);
        seq_t s;
        s[0] = w.elem_0;
        s[1] = w.elem_1;
        s[2] = w.elem_2;
        s[3] = w.elem_3;
        s[4] = w.elem_4;
        s[5] = w.elem_5;
        s[6] = w.elem_6;
        s[7] = w.elem_7;
        return s;
    endfunction

    // Builds a result word from an indexed sequence and the flag.
    function automatic out_word_t from_seq(input seq_t s, input logic flag);
        out_word_t w;
        w.out_0    = s[0];
        w.out_1    = s[1];
        w.out_2    = s[2];
        w.out_3    = s[3];
        w.out_4    = s[4];
        w.out_5    = s[5];
        w.out_6    = s[6];
        w.out_7    = s[7];
        w.has_next = flag;
        return w;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/nlp_scan.sv */
// ----------------------------------------------------------------------------
// nlp_scan
// First two pipeline stages: ascent compares, then the rightmost-ascent
// priority encoder that locates the pivot.
// ----------------------------------------------------------------------------
`default_nettype none

module nlp_scan (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire nlp_pkg::in_word_t in_word,
    output nlp_pkg::scan_t         scan
);

    // Stage 1 registers.
    logic              s1_valid_reg;
    nlp_pkg::seq_t     s1_seq_reg;
    nlp_pkg::len_t     s1_n_reg;
    nlp_pkg::asc_t     s1_asc_reg;

    nlp_pkg::seq_t     s1_seq_next;
    nlp_pkg::len_t     s1_n_next;
    nlp_pkg::asc_t     s1_asc_next;

    // Stage 2 register.
    nlp_pkg::scan_t    s2_reg;
    nlp_pkg::scan_t    s2_next;

    // Saturate the count and compare each neighboring pair inside it.
    always_comb
    begin
        s1_seq_next = nlp_pkg::to_seq(in_word);
        if (in_word.length > nlp_pkg::LEN_BITS'(nlp_pkg::MAX_ELEMS))
        begin
            s1_n_next = nlp_pkg::LEN_BITS'(nlp_pkg::MAX_ELEMS);
        end
        else
        begin
            s1_n_next = in_word.length;
        end
        for (int k = 0; k < nlp_pkg::MAX_ELEMS - 1; k++)
        begin
            s1_asc_next[k] = (nlp_pkg::LEN_BITS'(k + 1) < s1_n_next) &&
                             (s1_seq_next[k] < s1_seq_next[k + 1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_seq_reg <= s1_seq_next;
        s1_n_reg   <= s1_n_next;
        s1_asc_reg <= s1_asc_next;
    end

    // The pivot is the rightmost ascent.
    always_comb
    begin
        s2_next.valid = s1_valid_reg;
        s2_next.seq   = s1_seq_reg;
        s2_next.n     = s1_n_reg;
        s2_next.pivot = '0;
        s2_next.found = 1'b0;
        for (int k = 0; k < nlp_pkg::MAX_ELEMS - 1; k++)
        begin
            if (s1_asc_reg[k])
            begin
                s2_next.pivot = nlp_pkg::IDX_BITS'(k);
                s2_next.found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
        end
    end

    assign scan = s2_reg;

endmodule

`default_nettype wire

/* hw/rtl/next_lexicographic_permutation.sv */
// ----------------------------------------------------------------------------
// next_lexicographic_permutation
// Returns the next arrangement of a short sequence in lexicographic order.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                  Handshake
//  input     start, busy, data      word taken when start is high, busy low
//  result    done, result           word shown for one cycle with done high
//
//  Every word passes four register stages: ascent compares, pivot encoder,
//  successor search, then swap and reversal. Done rises together with the
//  result word; both are registered in the swap and reversal stage.
//  A new word may enter on every cycle; busy is always low.
//  Reset clears the valid bits of all four stages and the scan words that
//  carry them; other data registers keep whatever they hold.
//  The receiver cannot stall, so nothing is held back.
// ----------------------------------------------------------------------------
`default_nettype none

module next_lexicographic_permutation (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire nlp_pkg::in_word_t  data,
    output logic                    done,
    output nlp_pkg::out_word_t      result
);

    localparam int SUM_BITS = nlp_pkg::LEN_BITS + 1;

    nlp_pkg::scan_t     scan;

    // Stage 3 registers.
    nlp_pkg::scan_t     s3_reg;
    nlp_pkg::idx_t      s3_pick_reg;
    nlp_pkg::idx_t      s3_pick_next;
    nlp_pkg::elem_t     piv_val;

    // Stage 4 registers.
    logic               done_reg;
    nlp_pkg::out_word_t result_reg;
    nlp_pkg::out_word_t result_next;
    nlp_pkg::seq_t      perm;
    logic [SUM_BITS-1:0] mirror;
    nlp_pkg::idx_t      src;

    assign busy = 1'b0;

    nlp_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .in_word  (data),
        .scan     (scan)
    );

    // Rightmost element of the suffix that is larger than the pivot.
    always_comb
    begin
        piv_val      = scan.seq[scan.pivot];
        s3_pick_next = scan.pivot + nlp_pkg::IDX_BITS'(1);
        for (int k = 0; k < nlp_pkg::MAX_ELEMS; k++)
        begin
            if ((nlp_pkg::IDX_BITS'(k) > scan.pivot) &&
                (nlp_pkg::LEN_BITS'(k) < scan.n) &&
                (scan.seq[k] > piv_val))
            begin
                s3_pick_next = nlp_pkg::IDX_BITS'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
        end
        else
        begin
            s3_reg <= scan;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_pick_reg <= s3_pick_next;
    end

    // Swap the pivot with its successor and reverse the suffix in one
    // mapping: each suffix slot reads its mirrored slot of the swapped
    // sequence.
    always_comb
    begin
        perm   = s3_reg.seq;
        mirror = '0;
        src    = '0;
        if (s3_reg.found)
        begin
            for (int k = 0; k < nlp_pkg::MAX_ELEMS; k++)
            begin
                mirror = SUM_BITS'(s3_reg.n) + SUM_BITS'(s3_reg.pivot) -
                         SUM_BITS'(k);
                src    = mirror[nlp_pkg::IDX_BITS-1:0];
                if (nlp_pkg::IDX_BITS'(k) == s3_reg.pivot)
                begin
                    perm[k] = s3_reg.seq[s3_pick_reg];
                end
                else if ((nlp_pkg::IDX_BITS'(k) > s3_reg.pivot) &&
                         (nlp_pkg::LEN_BITS'(k) < s3_reg.n))
                begin
                    if (src == s3_pick_reg)
                    begin
                        perm[k] = s3_reg.seq[s3_reg.pivot];
                    end
                    else
                    begin
                        perm[k] = s3_reg.seq[src];
                    end
                end
            end
        end
        result_next = nlp_pkg::from_seq(perm, s3_reg.found);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A found pivot always has at least one element after it in the count.
    a_pivot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan.valid && scan.found |->
            (SUM_BITS'(scan.pivot) + SUM_BITS'(1)) < SUM_BITS'(scan.n))
        else $error("pivot outside the counted elements");

    // The successor lies after the pivot and inside the count.
    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s3_reg.valid && s3_reg.found |->
            (s3_pick_reg > s3_reg.pivot) &&
            (nlp_pkg::LEN_BITS'(s3_pick_reg) < s3_reg.n))
        else $error("successor index outside the suffix");

    // The successor is strictly larger than the pivot.
    a_pick_larger: assert property (@(posedge clk) disable iff (!rst_n)
        s3_reg.valid && s3_reg.found |->
            s3_reg.seq[s3_pick_reg] > s3_reg.seq[s3_reg.pivot])
        else $error("successor not larger than pivot");

    // A result strobe comes only from a scanned word, through the stage 3 register and then the done register.
    a_done_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(scan.valid, 2))
        else $error("result strobe without a scanned word");

endmodule

`default_nettype wire
